// File: hdl/sfy_pkg.sv
// Shared constants, types and the generator step function for the shuffle unit.
// No dependencies; imported by the generator, remainder, top-level and testbench files.
package sfy_pkg;

  localparam logic [63:0] SEED_RESET = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] STAR_MULT  = 64'd2685821657736338717;
  localparam int unsigned XS_SHR_A   = 12;
  localparam int unsigned XS_SHL     = 25;
  localparam int unsigned XS_SHR_B   = 27;

  // Configuration register indexes (byte address bit 3 with 8-byte registers)
  localparam logic [0:0] REG_SEED = 1'b0;
  localparam int unsigned PADDR_W = 4;

  // Requests from the sequencer to the generator
  typedef struct packed {
    logic load;   // reload state from the seed register
    logic step;   // advance once and form a new draw
  } rng_req_t;

  // One xorshift64 state update
  function automatic logic [63:0] xs_next(input logic [63:0] s);
    logic [63:0] x;
    x = s;
    x = x ^ (x >> XS_SHR_A);
    x = x ^ (x << XS_SHL);
    x = x ^ (x >> XS_SHR_B);
    return x;
  endfunction

endpackage

// File: hdl/sfy_stream_if.sv
// Valid/ready stream interfaces for the input and result channels.
// Depends on nothing; used by the top level of the shuffle unit.
interface sfy_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface sfy_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_out;
  logic        last_out;

  modport source (output valid, output value_out, output last_out, input ready);
  modport sink   (input valid, input value_out, input last_out, output ready);
endinterface

// File: hdl/sfy_rng.sv
// xorshift64* generator: state register plus a shared 32x32 multiplier that
// forms the low 64 bits of the star product over the LL, LH, HL and SUM phases. Uses sfy_pkg.
module sfy_rng
  import sfy_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rng_req_t    req_i,
  input  logic [63:0] seed_i,
  output logic [63:0] draw_o,
  output logic        draw_valid_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LL   = 3'd1;
  localparam logic [2:0] PH_LH   = 3'd2;
  localparam logic [2:0] PH_HL   = 3'd3;
  localparam logic [2:0] PH_SUM  = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [63:0] state_q, a_q, prod_q, acc_q;
  logic        valid_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    case (phase_q)
      PH_LL: begin
        mul_a = a_q[31:0];
        mul_b = STAR_MULT[31:0];
      end
      PH_LH: begin
        mul_a = a_q[31:0];
        mul_b = STAR_MULT[63:32];
      end
      default: begin
        mul_a = a_q[63:32];
        mul_b = STAR_MULT[31:0];
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    case (phase_q)
      PH_IDLE: phase_d = req_i.step ? PH_LL : PH_IDLE;
      PH_LL:   phase_d = PH_LH;
      PH_LH:   phase_d = PH_HL;
      PH_HL:   phase_d = PH_SUM;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      valid_q <= 1'b0;
      state_q <= SEED_RESET;
    end else begin
      phase_q <= phase_d;
      valid_q <= (phase_q == PH_SUM);
      if (req_i.load) begin
        state_q <= seed_i;
      end else if (req_i.step && phase_q == PH_IDLE) begin
        state_q <= xs_next(state_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_IDLE: begin
        if (req_i.step) begin
          a_q <= xs_next(state_q);
        end
      end
      PH_LL: prod_q <= mul_p;
      PH_LH: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      PH_HL: begin
        acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
        prod_q       <= mul_p;
      end
      PH_SUM: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
      default: ;
    endcase
  end

  assign draw_o       = acc_q;
  assign draw_valid_o = valid_q;

endmodule

// File: hdl/sfy_mod.sv
// Restoring remainder unit: 64-bit dividend modulo a narrow divisor, one
// dividend bit per cycle. Uses sfy_pkg for the shared import convention.
module sfy_mod
  import sfy_pkg::*;
#(
  parameter int unsigned DivW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [63:0]     dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] rem_o
);

  logic            busy_q, done_q;
  logic [5:0]      cnt_q;
  logic [63:0]     dvd_q;
  logic [DivW-1:0] div_q, rem_q;
  logic [DivW:0]   shifted;
  logic [DivW:0]   diff;

  assign shifted = {rem_q, dvd_q[63]};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      // keep the partial remainder below the divisor
      if (shifted >= {1'b0, div_q}) begin
        rem_q <= diff[DivW-1:0];
      end else begin
        rem_q <= shifted[DivW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: hdl/seeded_fisher_yates_shuffle_unit.sv
// Seeded Fisher-Yates shuffle unit: entry memory, sequencer and APB seed register.
// Depends on sfy_pkg, sfy_stream_if, sfy_rng and sfy_mod.
//
// Load a list of 64-bit words one beat at a time on in_i; the beat with last
// set closes the list (beats beyond DEPTH entries are dropped, but their last
// bit still closes it). The unit then reloads its xorshift64* generator from
// the seed register and shuffles the stored entries in place, from the top
// index down to 1: one generator step and a star multiply on a shared 32x32
// multiplier, a registered hand-over of the draw, a bit-serial remainder by
// i+1 with its done flag, and a read/read/write/write swap through the entry
// memory. The permuted list then leaves on out_o, each beat a memory read and
// then a load of the output register that waits while the receiver stalls,
// with last_out on the final beat; lists of one entry pass through unchanged.
// After its closing beat a list occupies the unit until its final beat is
// loaded into the output register, and in_i is not ready meanwhile. The seed
// is written through the APB port at byte address 0 and takes effect on the
// next shuffle.
module seeded_fisher_yates_shuffle_unit
  import sfy_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfy_in_if.sink              in_i,
  sfy_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Sequencer states
  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_DRAW     = 4'd1;
  localparam logic [3:0] S_GEN_WAIT = 4'd2;
  localparam logic [3:0] S_MOD_WAIT = 4'd3;
  localparam logic [3:0] S_RD_I     = 4'd4;
  localparam logic [3:0] S_RD_J     = 4'd5;
  localparam logic [3:0] S_WR_I     = 4'd6;
  localparam logic [3:0] S_WR_J     = 4'd7;
  localparam logic [3:0] S_OUT_RD   = 4'd8;
  localparam logic [3:0] S_OUT_WAIT = 4'd9;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] n_q, n_d;
  logic [IdxW-1:0] i_q, i_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [IdxW-1:0] k_q, k_d;
  logic [63:0]     seed_q;
  logic [63:0]     ti_q;

  // Entry memory, one write and one registered read per cycle
  logic [63:0]     mem [DEPTH];
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [63:0]     mem_wdata, rdata_q;

  logic            out_valid_q, out_load;
  logic [63:0]     out_value_q;
  logic            out_last_q;

  rng_req_t        rng_req;
  logic [63:0]     draw;
  logic            draw_valid;
  logic            mod_start, mod_done;
  logic [CntW-1:0] mod_rem;

  logic            in_acc, full;
  logic [CntW-1:0] n_close;

  // -------------------------------------------------------------- APB seed
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_SEED) ? seed_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (psel && penable && pwrite && paddr[3] == REG_SEED) begin
      seed_q <= pwdata;
    end
  end

  // -------------------------------------------------------------- units
  sfy_rng u_rng (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (rng_req),
    .seed_i       (seed_q),
    .draw_o       (draw),
    .draw_valid_o (draw_valid)
  );

  sfy_mod #(.DivW(CntW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (draw),
    .divisor_i  (CntW'(i_q) + CntW'(1)),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // -------------------------------------------------------------- sequencer
  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign full       = (count_q >= CntW'(DEPTH));
  assign n_close    = full ? count_q : count_q + CntW'(1);
  assign out_load   = (state_q == S_OUT_WAIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    n_d          = n_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    rng_req.load = 1'b0;
    rng_req.step = 1'b0;
    mod_start    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = i_q;
    mem_wdata    = rdata_q;
    mem_re       = 1'b0;
    mem_raddr    = i_q;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          // store unless full; drop the beat otherwise
          mem_we    = !full;
          mem_waddr = count_q[IdxW-1:0];
          mem_wdata = in_i.value;
          count_d   = n_close;
          if (in_i.last) begin
            rng_req.load = 1'b1;
            n_d          = n_close;
            k_d          = '0;
            i_d          = IdxW'(n_close - CntW'(1));
            state_d      = (n_close < CntW'(2)) ? S_OUT_RD : S_DRAW;
          end
        end
      end
      S_DRAW: begin
        rng_req.step = 1'b1;
        state_d      = S_GEN_WAIT;
      end
      S_GEN_WAIT: begin
        if (draw_valid) begin
          mod_start = 1'b1;
          state_d   = S_MOD_WAIT;
        end
      end
      S_MOD_WAIT: begin
        if (mod_done) begin
          j_d     = mod_rem[IdxW-1:0];
          state_d = S_RD_I;
        end
      end
      S_RD_I: begin
        mem_re    = 1'b1;
        mem_raddr = i_q;
        state_d   = S_RD_J;
      end
      S_RD_J: begin
        mem_re    = 1'b1;
        mem_raddr = j_q;
        state_d   = S_WR_I;
      end
      S_WR_I: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = rdata_q;
        state_d   = S_WR_J;
      end
      S_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = ti_q;
        if (i_q == IdxW'(1)) begin
          state_d = S_OUT_RD;
        end else begin
          i_d     = i_q - IdxW'(1);
          state_d = S_DRAW;
        end
      end
      S_OUT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = k_q;
        state_d   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        // hold the fetched entry until the output register frees up
        if (out_load) begin
          if (k_q == IdxW'(n_q - CntW'(1))) begin
            count_d = '0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + IdxW'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    i_q <= i_d;
    j_q <= j_d;
    k_q <= k_d;
    // old entry i, captured the cycle after its read
    if (state_q == S_RD_J) begin
      ti_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // -------------------------------------------------------------- output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= rdata_q;
      out_last_q  <= (k_q == IdxW'(n_q - CntW'(1)));
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = out_value_q;
  assign out_o.last_out  = out_last_q;

endmodule

// File: tb/sfy_tb_pkg.sv
// Scoreboard for the shuffle unit: a predictor of the load, shuffle and emit sequence.
// Depends on sfy_pkg for the seed reset and the xorshift64* constants.
package sfy_tb_pkg;
  import sfy_pkg::*;

  localparam int unsigned STORE_DEPTH = 64;

  typedef struct packed {
    logic [63:0] value;
    logic        last;
  } shuffled_beat_t;

  class shuffle_scoreboard;
    logic [63:0]    seed_reg;
    logic [63:0]    entries [STORE_DEPTH];
    int unsigned    fill;
    logic [63:0]    gen_state;
    shuffled_beat_t awaited_q [$];
    int unsigned    errors;
    int unsigned    beats_in;
    int unsigned    lists_closed;
    int unsigned    beats_checked;

    function new();
      seed_reg      = SEED_RESET;
      gen_state     = SEED_RESET;
      fill          = 0;
      errors        = 0;
      beats_in      = 0;
      lists_closed  = 0;
      beats_checked = 0;
    endfunction

    function void set_seed(logic [63:0] s);
      seed_reg = s;
    endfunction

    // advance the xorshift64 state and scramble it with the star multiplier
    function logic [63:0] star_draw();
      logic [63:0] x;
      x = gen_state;
      x = x ^ (x >> XS_SHR_A);
      x = x ^ (x << XS_SHL);
      x = x ^ (x >> XS_SHR_B);
      gen_state = x;
      return x * STAR_MULT;
    endfunction

    function void shuffle_entries();
      logic [63:0] r;
      logic [63:0] held;
      int unsigned i;
      int unsigned j;
      gen_state = seed_reg;
      if (fill < 2) return;
      for (i = fill - 1; i > 0; i--) begin
        r          = star_draw();
        j          = int'(r % 64'(i + 1));
        held       = entries[i];
        entries[i] = entries[j];
        entries[j] = held;
      end
    endfunction

    // store one accepted beat; a closing beat queues the whole permuted list
    function void note_input(logic [63:0] value, logic last);
      shuffled_beat_t b;
      int unsigned k;
      beats_in++;
      if (fill < STORE_DEPTH) begin
        entries[fill] = value;
        fill++;
      end
      if (last) begin
        shuffle_entries();
        for (k = 0; k < fill; k++) begin
          b.value = entries[k];
          b.last  = (k + 1 == fill);
          awaited_q.push_back(b);
        end
        fill = 0;
        lists_closed++;
      end
    endfunction

    function void check_result(logic [63:0] value, logic last);
      shuffled_beat_t b;
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected result beat value_out %h last_out %b", $time, value, last);
        errors++;
        return;
      end
      b = awaited_q.pop_front();
      beats_checked++;
      if (value !== b.value) begin
        $display("%0t: value_out expected %h actual %h", $time, b.value, value);
        errors++;
      end
      if (last !== b.last) begin
        $display("%0t: last_out expected %b actual %b", $time, b.last, last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited_q.size();
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// Top-level testbench for seeded_fisher_yates_shuffle_unit: stimulus, seed writes and checks.
// Depends on sfy_pkg, sfy_stream_if and sfy_tb_pkg.
module tb_top;
  import sfy_pkg::*;
  import sfy_tb_pkg::*;

  // Quiet-cycle limit: the longest silent stretch is a full 64-entry shuffle;
  // allow several times that.
  localparam int unsigned QUIET_LIMIT  = 25000;
  localparam int unsigned ITEM_TARGET  = 410;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned DRAIN        = 24;
  localparam logic [PADDR_W-1:0] SEED_ADDR = {REG_SEED, 3'b000};

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  sfy_in_if  in_bus ();
  sfy_out_if out_bus ();

  shuffle_scoreboard sb;

  // Shared knobs between the main sequence and the receiver
  bit          calm;       // suppress idling on both sides
  bit          hold_ask;   // ask the receiver for a long hold-off
  int unsigned seed_writes;

  seeded_fisher_yates_shuffle_unit #(
    .DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Pick a list entry: mostly random words, with zeros, all-ones and
  // single set bits mixed in so both values reach every bit.
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Write the seed register, then read it back over the same port.
  // Call only while the unit is idle.
  task automatic write_seed(input logic [63:0] s);
    logic [63:0] rd;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= SEED_ADDR;
    pwdata  <= s;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_seed(s);
    seed_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== s) begin
      $display("%0t: seed readback expected %h actual %h", $time, s, rd);
      sb.errors++;
    end
  endtask

  // Offer one beat and hold it until the unit takes it. Valid stays high
  // into the next beat unless an idle gap is drawn.
  task automatic send_beat(input logic [63:0] value, input logic last);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= value;
    in_bus.last  <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_input(value, last);
  endtask

  task automatic send_list(input int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) send_beat(pick_word(), k + 1 == len);
  endtask

  // Wait until every predicted beat has left the unit, then let it settle
  // back to idle before touching the seed.
  task automatic await_idle();
    in_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Receiver: accept result beats, stalling about a quarter of the time,
  // or hold off entirely for a long stretch when asked.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= calm || ($urandom_range(0, 99) >= 25);
      end
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) sb.check_result(out_bus.value_out, out_bus.last_out);
    end
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    int unsigned phase;
    int unsigned phase_start;
    int unsigned len;
    sb          = new();
    calm        = 1'b0;
    hold_ask    = 1'b0;
    seed_writes = 0;
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_bus.valid <= 1'b0;
    in_bus.value <= '0;
    in_bus.last  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset seed first. A single entry must pass through untouched.
    send_beat('1, 1'b1);
    // Two entries: exercise the extremes of the value field.
    send_beat(64'd0, 1'b0);
    send_beat('1, 1'b1);
    send_beat(64'h5555_5555_5555_5555, 1'b0);
    send_beat(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    send_beat(64'h8000_0000_0000_0001, 1'b1);
    // Seeds of one and all-ones, then a zero seed where every swap index is zero.
    await_idle();
    write_seed(64'd1);
    send_list(4);
    await_idle();
    write_seed('1);
    send_list(4);
    await_idle();
    write_seed(64'd0);
    send_list(5);

    // Random phases: a fresh seed each phase, lists of mostly short length.
    phase = 0;
    while (sb.beats_in < ITEM_TARGET) begin
      await_idle();
      case (phase % 6)
        1: write_seed(64'd1);
        2: write_seed('1);
        3: write_seed(64'd0);
        default: write_seed({$urandom, $urandom});
      endcase
      // phase two runs without any idling on either side
      calm = (phase == 2);
      // phase three holds the receiver off so the unit backs up into in_i
      if (phase == 3) hold_ask = 1'b1;
      // overfill the store once: the surplus beats are dropped, the last still closes
      if (phase == 0) send_list(STORE_DEPTH + 6);
      phase_start = sb.beats_in;
      while (sb.beats_in - phase_start < 50 && sb.beats_in < ITEM_TARGET) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_list(len);
      end
      phase++;
    end
    calm = 1'b0;

    // Drain: wait for every predicted beat, then watch a little longer for strays.
    in_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("shuffle run: %0d beats loaded into %0d lists, %0d shuffled beats checked",
             sb.beats_in, sb.lists_closed, sb.beats_checked);
    $display("seed written %0d times incl. 0, 1 and all-ones; store overflow and hold-off seen",
             seed_writes);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sfy_pkg.sv
hdl/sfy_stream_if.sv
hdl/sfy_rng.sv
hdl/sfy_mod.sv
hdl/seeded_fisher_yates_shuffle_unit.sv
tb/sfy_tb_pkg.sv
tb/tb_top.sv
